// ===== hdl/eth_ipv4_l4_header_parser_macros.svh =====
// ============================================================================
// Assertion macros for the Ethernet / IPv4 / L4 header parser
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ============================================================================
`ifndef ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH
`define ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define EHP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define EHP_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define EHP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)

`define EHP_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/ehp_pkg.sv =====
// ============================================================================
// ehp_pkg
// Types and constants shared by the header parser modules.
// ============================================================================
`default_nettype none

package ehp_pkg;

    localparam int MAX_FRAME_BYTES = 16384;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int ETH_HDR_BYTES   = 14;
    localparam int UDP_HDR_BYTES   = 8;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Byte offsets inside the frame; OFS_DOFF counts from the transport header start.
    localparam int OFS_ETYPE_HI  = 12;
    localparam int OFS_ETYPE_LO  = 13;
    localparam int OFS_IHL       = ETH_HDR_BYTES;
    localparam int OFS_PROTO     = ETH_HDR_BYTES + 9;
    localparam int OFS_SRC_FIRST = ETH_HDR_BYTES + 12;
    localparam int OFS_DST_FIRST = ETH_HDR_BYTES + 16;
    localparam int OFS_DST_END   = ETH_HDR_BYTES + 20;
    localparam int OFS_DOFF      = 12;

    localparam int PAYLOAD_W   = 15;
    localparam int PAYLOAD_MAX = (1 << PAYLOAD_W) - 1;

    localparam int IN_DATA_W   = 16;
    localparam int OUT_USED_W  = 32 + 6 + 6 + 32 + 32 + 16 + 16 + PAYLOAD_W + 32;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] STAT_PACKETS   = 3'd0;
    localparam logic [2:0] STAT_TCP_PKTS  = 3'd1;
    localparam logic [2:0] STAT_UDP_PKTS  = 3'd2;
    localparam logic [2:0] STAT_TCP_BYTES = 3'd3;
    localparam logic [2:0] STAT_UDP_BYTES = 3'd4;

    typedef enum logic [2:0] {
        KIND_NON_IP   = 3'd0,
        KIND_TCP      = 3'd1,
        KIND_UDP      = 3'd2,
        KIND_OTHER_IP = 3'd3,
        KIND_STATS    = 3'd4
    } ehp_kind_t;

    // One entry of the queue between the byte front end and the back end.
    typedef struct packed {
        logic             is_stat;
        logic [2:0]       stat_index;
        logic             eth_ok;
        logic [7:0]       protocol;
        logic [3:0]       ihl;
        logic [3:0]       doff;
        logic [31:0]      src_addr;
        logic [31:0]      dst_addr;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [POS_W-1:0] frame_len;
    } ehp_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ehp_qstat_t;

endpackage

`default_nettype wire

// ===== hdl/ehp_front.sv =====
// ============================================================================
// ehp_front
// Byte front end: tracks the byte position, latches header fields and
// pushes one record per frame end or statistics request.
// ============================================================================
`default_nettype none

module ehp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ehp_pkg::IN_DATA_W-1:0] s_tdata,  // data_byte, stat_index
    input  wire logic                          s_tlast,
    input  wire logic [0:0]                    s_tuser,  // req_type
    input  wire ehp_pkg::ehp_qstat_t           q_status,
    output logic                               q_push,
    output ehp_pkg::ehp_rec_t                  q_rec
);
    import ehp_pkg::*;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [15:0]      etype_reg, etype_next;
    logic [3:0]       ihl_reg,   ihl_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg,   src_next;
    logic [31:0]      dst_reg,   dst_next;
    logic [15:0]      sport_reg, sport_next;
    logic [15:0]      dport_reg, dport_next;
    logic [3:0]       doff_reg,  doff_next;

    logic             accept;
    logic             is_stat;
    logic [7:0]       data_byte;
    logic [2:0]       stat_index;
    logic             capture;
    logic [POS_W-1:0] l4_start;

    assign s_tready   = !q_status.full;
    assign accept     = s_tvalid && s_tready;
    assign is_stat    = s_tuser[0];
    assign data_byte  = s_tdata[7:0];
    assign stat_index = s_tdata[10:8];
    assign capture    = accept && !is_stat && (pos_reg < POS_W'(MAX_FRAME_BYTES));

    always_comb
    begin
        pos_next   = pos_reg;
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        doff_next  = doff_reg;
        if (capture)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(OFS_ETYPE_HI) || pos_reg == POS_W'(OFS_ETYPE_LO))
                etype_next = {etype_reg[7:0], data_byte};
            if (pos_reg == POS_W'(OFS_IHL))
                ihl_next = data_byte[3:0];
            if (pos_reg == POS_W'(OFS_PROTO))
                proto_next = data_byte;
            if (pos_reg >= POS_W'(OFS_SRC_FIRST) && pos_reg < POS_W'(OFS_DST_FIRST))
                src_next = {src_reg[23:0], data_byte};
            if (pos_reg >= POS_W'(OFS_DST_FIRST) && pos_reg < POS_W'(OFS_DST_END))
                dst_next = {dst_reg[23:0], data_byte};
            // The transport start follows the IHL already updated by this byte.
            if (pos_reg == l4_start || pos_reg == l4_start + POS_W'(1))
                sport_next = {sport_reg[7:0], data_byte};
            if (pos_reg == l4_start + POS_W'(2) || pos_reg == l4_start + POS_W'(3))
                dport_next = {dport_reg[7:0], data_byte};
            if (pos_reg == l4_start + POS_W'(OFS_DOFF))
                doff_next = data_byte[7:4];
        end
    end

    assign l4_start = POS_W'(ETH_HDR_BYTES) + POS_W'({ihl_next, 2'b00});

    assign q_push = accept && (is_stat || s_tlast);

    always_comb
    begin
        q_rec            = '0;
        q_rec.is_stat    = is_stat;
        q_rec.stat_index = stat_index;
        if (!is_stat)
        begin
            q_rec.eth_ok    = (etype_next == ETHERTYPE_IPV4);
            q_rec.protocol  = proto_next;
            q_rec.ihl       = ihl_next;
            q_rec.doff      = doff_next;
            q_rec.src_addr  = src_next;
            q_rec.dst_addr  = dst_next;
            q_rec.sport     = sport_next;
            q_rec.dport     = dport_next;
            q_rec.frame_len = pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            doff_reg  <= '0;
        end
        else if (accept && !is_stat && s_tlast)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            doff_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            etype_reg <= etype_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            doff_reg  <= doff_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ehp_queue.sv =====
// ============================================================================
// ehp_queue
// Short first-in first-out queue of records between front and back end.
// ============================================================================
`default_nettype none

module ehp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ehp_pkg::ehp_rec_t   push_rec,
    input  wire logic                pop,
    output ehp_pkg::ehp_rec_t        head_rec,
    output ehp_pkg::ehp_qstat_t      status
);
    import ehp_pkg::*;

    ehp_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_rec     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

// ===== hdl/ehp_back.sv =====
// ============================================================================
// ehp_back
// Back end: classifies finished frames, keeps the packet and byte counters
// and drives the registered result word.
// ============================================================================
`default_nettype none

module ehp_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ehp_pkg::ehp_rec_t               head_rec,
    input  wire ehp_pkg::ehp_qstat_t             q_status,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // packet_number, ip_header_bytes, l4_header_bytes, source_address,
    // destination_address, source port, destination port, payload_bytes,
    // stat_value, zero fill
    output logic [ehp_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [2:0]                           m_tuser   // result_kind
);
    import ehp_pkg::*;

    logic [31:0] frames_reg,    frames_next;
    logic [31:0] tcp_pkts_reg,  tcp_pkts_next;
    logic [31:0] udp_pkts_reg,  udp_pkts_next;
    logic [31:0] tcp_bytes_reg, tcp_bytes_next;
    logic [31:0] udp_bytes_reg, udp_bytes_next;

    logic                  out_valid_reg;
    ehp_kind_t             out_kind_reg,  out_kind_next;
    logic [OUT_DATA_W-1:0] out_data_reg,  out_data_next;

    ehp_kind_t        kind;
    logic [31:0]      packet_number;
    logic [5:0]       ip_bytes;
    logic [5:0]       l4_bytes;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      l4_sport;
    logic [15:0]      l4_dport;
    logic [PAYLOAD_W-1:0] payload;
    logic [31:0]      stat_value;
    logic [POS_W:0]   hdr_total;
    logic [POS_W:0]   len_ext;
    logic [POS_W:0]   payload_full;

    assign q_pop    = !q_status.empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    assign len_ext   = (POS_W + 1)'(head_rec.frame_len);

    always_comb
    begin
        frames_next    = frames_reg;
        tcp_pkts_next  = tcp_pkts_reg;
        udp_pkts_next  = udp_pkts_reg;
        tcp_bytes_next = tcp_bytes_reg;
        udp_bytes_next = udp_bytes_reg;

        kind          = KIND_NON_IP;
        packet_number = '0;
        ip_bytes      = '0;
        l4_bytes      = '0;
        src_addr      = '0;
        dst_addr      = '0;
        l4_sport      = '0;
        l4_dport      = '0;
        payload       = '0;
        stat_value    = '0;
        hdr_total     = '0;
        payload_full  = '0;

        if (head_rec.is_stat)
        begin
            kind = KIND_STATS;
            case (head_rec.stat_index)
                STAT_PACKETS:   stat_value = frames_reg;
                STAT_TCP_PKTS:  stat_value = tcp_pkts_reg;
                STAT_UDP_PKTS:  stat_value = udp_pkts_reg;
                STAT_TCP_BYTES: stat_value = tcp_bytes_reg;
                STAT_UDP_BYTES: stat_value = udp_bytes_reg;
                default:        stat_value = '0;
            endcase
        end
        else
        begin
            frames_next   = frames_reg + 32'd1;
            packet_number = frames_next;
            if (head_rec.eth_ok)
            begin
                ip_bytes = {head_rec.ihl, 2'b00};
                src_addr = head_rec.src_addr;
                dst_addr = head_rec.dst_addr;
                if (head_rec.protocol == PROTO_TCP)
                begin
                    kind           = KIND_TCP;
                    l4_bytes       = {head_rec.doff, 2'b00};
                    tcp_pkts_next  = tcp_pkts_reg + 32'd1;
                    tcp_bytes_next = tcp_bytes_reg + 32'(head_rec.frame_len);
                end
                else if (head_rec.protocol == PROTO_UDP)
                begin
                    kind           = KIND_UDP;
                    l4_bytes       = 6'(UDP_HDR_BYTES);
                    udp_pkts_next  = udp_pkts_reg + 32'd1;
                    udp_bytes_next = udp_bytes_reg + 32'(head_rec.frame_len);
                end
                else
                begin
                    kind = KIND_OTHER_IP;
                end
                if (kind == KIND_TCP || kind == KIND_UDP)
                begin
                    l4_sport = head_rec.sport;
                    l4_dport = head_rec.dport;
                end
                hdr_total    = (POS_W + 1)'(ETH_HDR_BYTES) + (POS_W + 1)'(ip_bytes)
                             + (POS_W + 1)'(l4_bytes);
                payload_full = (len_ext > hdr_total) ? len_ext - hdr_total : '0;
                if (payload_full > (POS_W + 1)'(PAYLOAD_MAX))
                    payload = PAYLOAD_W'(PAYLOAD_MAX);
                else
                    payload = PAYLOAD_W'(payload_full);
            end
        end

        out_kind_next = kind;
        out_data_next = OUT_DATA_W'({stat_value, payload, l4_dport, l4_sport,
                                     dst_addr, src_addr, l4_bytes, ip_bytes,
                                     packet_number});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= '0;
            tcp_pkts_reg  <= '0;
            udp_pkts_reg  <= '0;
            tcp_bytes_reg <= '0;
            udp_bytes_reg <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_NON_IP;
        end
        else
        begin
            if (q_pop)
            begin
                frames_reg    <= frames_next;
                tcp_pkts_reg  <= tcp_pkts_next;
                udp_pkts_reg  <= udp_pkts_next;
                tcp_bytes_reg <= tcp_bytes_next;
                udp_bytes_reg <= udp_bytes_next;
                out_valid_reg <= 1'b1;
                out_kind_reg  <= out_kind_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/eth_ipv4_l4_header_parser.sv =====
// Path: a result word comes from a record in the queue, via the output register.
// Throughput: one input word per cycle while the four-entry record queue is not
// full; the queue and output register let the byte side run while the result side stalls.
// Reset: rst_n clears the frame tracker, queue, counters and output valid
// at once; no clearing pass is needed.
// ============================================================================
// eth_ipv4_l4_header_parser
// Ethernet / IPv4 / TCP / UDP header parser with packet and byte statistics.
// ============================================================================
`default_nettype none

`include "eth_ipv4_l4_header_parser_macros.svh"

module eth_ipv4_l4_header_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ehp_pkg::IN_DATA_W-1:0]   s_tdata,   // data_byte, stat_index, zero fill
    input  wire logic                            s_tlast,   // last_byte
    input  wire logic [0:0]                      s_tuser,   // req_type
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // packet_number, ip_header_bytes, l4_header_bytes, source_address,
    // destination_address, source port, destination port, payload_bytes,
    // stat_value, zero fill
    output logic [ehp_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [2:0]                           m_tuser    // result_kind
);
    import ehp_pkg::*;

    ehp_qstat_t q_status;
    ehp_rec_t   push_rec;
    ehp_rec_t   head_rec;
    logic       q_push;
    logic       q_pop;

    ehp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    ehp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    ehp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `EHP_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, q_push && q_status.full, "queue overflow")
    `EHP_ASSERT_IMP(a_mid_frame_no_push, clk, rst_n, s_tvalid && s_tready && !s_tuser[0] && !s_tlast, !q_push, "record pushed for a byte inside a frame")
    `EHP_ASSERT_IMP(a_stat_zero_on_frames, clk, rst_n, m_tvalid && (m_tuser != KIND_STATS), m_tdata[186:155] == 32'd0, "counter value on a frame summary")
    `EHP_ASSERT_IMP(a_pop_only_when_filled, clk, rst_n, q_pop, !q_status.empty, "pop from an empty queue")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Testbench for eth_ipv4_l4_header_parser
// Sends generated frames one byte per word, mixed with statistics reads, and
// checks every summary word against an in-bench model of the parser.
// ============================================================================

module testbench;

    import ehp_pkg::*;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_STATS = 1'b1;

    localparam int RANDOM_WORDS  = 320;
    localparam int RANDOM_FRAMES = 3;

    typedef struct packed {
        ehp_kind_t   kind;
        logic [31:0] packet_number;
        logic [5:0]  ip_header_bytes;
        logic [5:0]  l4_header_bytes;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [14:0] payload_bytes;
        logic [31:0] stat_value;
    } summary_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    // Parser model state.
    int unsigned  byte_pos;
    logic [15:0]  etype;
    logic [3:0]   ihl;
    logic [7:0]   proto;
    logic [31:0]  src_addr;
    logic [31:0]  dst_addr;
    logic [15:0]  sport_latch;
    logic [15:0]  dport_latch;
    logic [3:0]   doff;
    logic [31:0]  frames_seen;
    logic [31:0]  tcp_frames;
    logic [31:0]  udp_frames;
    logic [31:0]  tcp_bytes;
    logic [31:0]  udp_bytes;

    summary_t     pending_summaries[$];
    logic [7:0]   frame_bytes[$];
    int           kind_count[5];
    int           errors = 0;
    int           words_sent = 0;
    bit           idle_on = 1'b1;

    eth_ipv4_l4_header_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic void clear_frame_state();
        byte_pos    = 0;
        etype       = '0;
        ihl         = '0;
        proto       = '0;
        src_addr    = '0;
        dst_addr    = '0;
        sport_latch = '0;
        dport_latch = '0;
        doff        = '0;
    endfunction

    // Applies one accepted word to the model and queues the summary it causes.
    function automatic void parse_word(logic req, logic [7:0] b, logic last, logic [2:0] idx);
        summary_t    s;
        int unsigned l4_start;
        int unsigned len;
        int unsigned ip_bytes;
        int unsigned l4_bytes;
        int unsigned hdrs;
        int unsigned payload;
        s = '0;
        if (req == REQ_STATS)
        begin
            s.kind = KIND_STATS;
            case (idx)
                STAT_PACKETS:   s.stat_value = frames_seen;
                STAT_TCP_PKTS:  s.stat_value = tcp_frames;
                STAT_UDP_PKTS:  s.stat_value = udp_frames;
                STAT_TCP_BYTES: s.stat_value = tcp_bytes;
                STAT_UDP_BYTES: s.stat_value = udp_bytes;
                default:        s.stat_value = '0;
            endcase
            pending_summaries.push_back(s);
            return;
        end
        if (byte_pos < MAX_FRAME_BYTES)
        begin
            if (byte_pos == 12 || byte_pos == 13)
                etype = {etype[7:0], b};
            if (byte_pos == ETH_HDR_BYTES)
                ihl = b[3:0];
            if (byte_pos == ETH_HDR_BYTES + 9)
                proto = b;
            if (byte_pos >= ETH_HDR_BYTES + 12 && byte_pos < ETH_HDR_BYTES + 16)
                src_addr = {src_addr[23:0], b};
            if (byte_pos >= ETH_HDR_BYTES + 16 && byte_pos < ETH_HDR_BYTES + 20)
                dst_addr = {dst_addr[23:0], b};
            // The transport start follows the IHL just latched, even on its own byte.
            l4_start = ETH_HDR_BYTES + 4 * ihl;
            if (byte_pos == l4_start || byte_pos == l4_start + 1)
                sport_latch = {sport_latch[7:0], b};
            if (byte_pos == l4_start + 2 || byte_pos == l4_start + 3)
                dport_latch = {dport_latch[7:0], b};
            if (byte_pos == l4_start + 12)
                doff = b[7:4];
            byte_pos++;
        end
        if (!last)
            return;
        len = byte_pos;
        frames_seen++;
        s.packet_number = frames_seen;
        if (etype != ETHERTYPE_IPV4)
        begin
            s.kind = KIND_NON_IP;
            pending_summaries.push_back(s);
            clear_frame_state();
            return;
        end
        ip_bytes = 4 * ihl;
        l4_bytes = 0;
        if (proto == PROTO_TCP)
        begin
            s.kind   = KIND_TCP;
            l4_bytes = 4 * doff;
            tcp_frames++;
            tcp_bytes += len;
        end
        else if (proto == PROTO_UDP)
        begin
            s.kind   = KIND_UDP;
            l4_bytes = UDP_HDR_BYTES;
            udp_frames++;
            udp_bytes += len;
        end
        else
        begin
            s.kind = KIND_OTHER_IP;
        end
        hdrs    = ETH_HDR_BYTES + ip_bytes + l4_bytes;
        payload = (len > hdrs) ? len - hdrs : 0;
        if (payload > 32'h7FFF)
            payload = 32'h7FFF;
        s.ip_header_bytes     = ip_bytes[5:0];
        s.l4_header_bytes     = l4_bytes[5:0];
        s.source_address      = src_addr;
        s.destination_address = dst_addr;
        if (s.kind == KIND_TCP || s.kind == KIND_UDP)
        begin
            s.l4_sport = sport_latch;
            s.l4_dport = dport_latch;
        end
        s.payload_bytes = payload[14:0];
        pending_summaries.push_back(s);
        clear_frame_state();
    endfunction

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        summary_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_summaries.size() == 0)
            begin
                $error("unexpected result word, kind %0d", m_tuser);
                errors++;
            end
            else
            begin
                want = pending_summaries.pop_front();
                check_field("result_kind", want.kind, m_tuser);
                check_field("packet_number", want.packet_number, m_tdata[31:0]);
                check_field("ip_header_bytes", want.ip_header_bytes, m_tdata[37:32]);
                check_field("l4_header_bytes", want.l4_header_bytes, m_tdata[43:38]);
                check_field("source_address", want.source_address, m_tdata[75:44]);
                check_field("destination_address", want.destination_address,
                            m_tdata[107:76]);
                check_field("source port", want.l4_sport, m_tdata[123:108]);
                check_field("destination port", want.l4_dport, m_tdata[139:124]);
                check_field("payload_bytes", want.payload_bytes, m_tdata[154:140]);
                check_field("stat_value", want.stat_value, m_tdata[186:155]);
                check_field("zero fill", 0, m_tdata[OUT_DATA_W-1:187]);
                kind_count[want.kind]++;
            end
        end
        m_tready <= idle_on ? ($urandom_range(99) >= 13) : 1'b1;
    end

    task automatic send_word(logic req, logic [7:0] b, logic last, logic [2:0] idx);
        while (idle_on && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 11){1'b0}}, idx, b};
        s_tlast  <= last;
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_word(req, b, last, idx);
        words_sent++;
    endtask

    task automatic send_stats(logic [2:0] idx);
        send_word(REQ_STATS, 8'($urandom), 1'($urandom), idx);
    endtask

    // Sends the frame held in frame_bytes, slipping in statistics reads now and then.
    task automatic send_frame(int stats_pct);
        foreach (frame_bytes[i])
        begin
            if ($urandom_range(99) < stats_pct)
                send_stats(3'($urandom));
            send_word(REQ_FRAME, frame_bytes[i], i == frame_bytes.size() - 1, 3'($urandom));
        end
    endtask

    // Holds the sender off until every pending summary has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random bytes with the header fields laid over them where the frame reaches.
    task automatic make_frame(logic [15:0] et, logic [7:0] ver_ihl, logic [7:0] prot,
                              logic [3:0] data_ofs, int total);
        int l4_start;
        frame_bytes.delete();
        for (int i = 0; i < total; i++)
            frame_bytes.push_back(8'($urandom));
        l4_start = ETH_HDR_BYTES + 4 * ver_ihl[3:0];
        if (total > l4_start + 12)
            frame_bytes[l4_start + 12] = {data_ofs, frame_bytes[l4_start + 12][3:0]};
        if (total > 12)
            frame_bytes[12] = et[15:8];
        if (total > 13)
            frame_bytes[13] = et[7:0];
        if (total > ETH_HDR_BYTES)
            frame_bytes[ETH_HDR_BYTES] = ver_ihl;
        if (total > ETH_HDR_BYTES + 9)
            frame_bytes[ETH_HDR_BYTES + 9] = prot;
    endtask

    task automatic poke32(int at, logic [31:0] v);
        for (int i = 0; i < 4; i++)
            frame_bytes[at + i] = v[31 - 8 * i -: 8];
    endtask

    task automatic test_non_ipv4();
        make_frame(16'h86DD, 8'h45, PROTO_TCP, 4'd5, 64);
        send_frame(0);
        // A single-byte frame never reaches the ethertype.
        make_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 4'd5, 1);
        send_frame(0);
        make_frame(16'h0008, 8'h45, PROTO_UDP, 4'd5, 13);
        send_frame(0);
    endtask

    task automatic test_protocols();
        make_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 4'd5, 14 + 20 + 20 + 10);
        poke32(26, 32'hFFFF_FFFF);
        poke32(30, 32'h0000_0000);
        poke32(34, 32'hFFFF_FFFF);
        send_frame(0);
        make_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 4'd0, 14 + 20 + 8);
        poke32(26, 32'h0000_0000);
        poke32(30, 32'hFFFF_FFFF);
        poke32(34, 32'h0000_0000);
        send_frame(0);
        make_frame(ETHERTYPE_IPV4, 8'h45, 8'd1, 4'd5, 90);
        send_frame(0);
        make_frame(ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, 4'd15, 14 + 60 + 60 + 5);
        send_frame(0);
        // The version nibble is ignored, and a zero data offset gives no TCP header.
        make_frame(ETHERTYPE_IPV4, 8'h65, PROTO_TCP, 4'd0, 70);
        send_frame(0);
        // Frame ends inside the IP header, so the payload clamps at zero.
        make_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 4'd5, 28);
        send_frame(0);
        make_frame(ETHERTYPE_IPV4, 8'hFF, 8'hFF, 4'd5, 40);
        send_frame(0);
    endtask

    task automatic test_overlap();
        make_frame(ETHERTYPE_IPV4, 8'h40, PROTO_TCP, 4'd7, 60);
        send_frame(0);
        make_frame(ETHERTYPE_IPV4, 8'h42, PROTO_UDP, 4'd3, 50);
        send_frame(0);
        make_frame(ETHERTYPE_IPV4, 8'h43, PROTO_TCP, 4'd9, 45);
        send_frame(0);
    endtask

    task automatic test_stats();
        for (int i = 0; i < 8; i++)
            send_stats(3'(i));
        make_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 4'd0, 48);
        send_frame(50);
        for (int i = 0; i < 5; i++)
            send_stats(3'(i));
    endtask

    task automatic test_random();
        int          first_word;
        int          frames_sent;
        int          pick;
        int          body;
        logic [3:0]  hl;
        logic [3:0]  version;
        logic [7:0]  prot;
        logic [3:0]  data_ofs;
        logic [15:0] et;
        bit          drained;
        first_word  = words_sent;
        frames_sent = 0;
        drained     = 1'b0;
        while (words_sent - first_word < RANDOM_WORDS || frames_sent < RANDOM_FRAMES)
        begin
            // A stretch in the middle runs with neither side idling.
            idle_on = !((words_sent - first_word) >= 100 && (words_sent - first_word) < 240);
            if (!drained && words_sent - first_word >= 260)
            begin
                drain();
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_stats(3'($urandom));
            end
            else if (pick < 16)
            begin
                make_frame(16'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                           $urandom_range(1, 40));
                send_frame(3);
                frames_sent++;
            end
            else
            begin
                et       = ($urandom_range(99) < 90) ? ETHERTYPE_IPV4 : 16'($urandom);
                hl       = ($urandom_range(99) < 85) ? 4'($urandom_range(5, 15))
                                                     : 4'($urandom_range(0, 4));
                version  = ($urandom_range(99) < 90) ? 4'd4 : 4'($urandom);
                pick     = $urandom_range(99);
                prot     = (pick < 40) ? PROTO_TCP : (pick < 80) ? PROTO_UDP : 8'($urandom);
                data_ofs = ($urandom_range(99) < 85) ? 4'($urandom_range(5, 15)) : 4'($urandom);
                body     = ETH_HDR_BYTES + 4 * hl
                         + ((prot == PROTO_TCP) ? 4 * data_ofs : UDP_HDR_BYTES)
                         + $urandom_range(0, 48);
                if ($urandom_range(99) < 10)
                    body = $urandom_range(1, body);
                make_frame(et, {version, hl}, prot, data_ofs, body);
                send_frame(3);
                frames_sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        int waited;
        clear_frame_state();
        frames_seen = '0;
        tcp_frames  = '0;
        udp_frames  = '0;
        tcp_bytes   = '0;
        udp_bytes   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_non_ipv4();
        test_protocols();
        drain();
        test_overlap();
        test_stats();
        drain();
        test_random();

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_summaries.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_summaries.size() != 0)
        begin
            $error("%0d summaries never arrived", pending_summaries.size());
            errors++;
        end

        $display("Sent %0d words: %0d TCP, %0d UDP, %0d other IP and %0d non-IPv4 frames,",
                 words_sent, kind_count[KIND_TCP], kind_count[KIND_UDP],
                 kind_count[KIND_OTHER_IP], kind_count[KIND_NON_IP]);
        $display("plus %0d statistics reads, including short frames and overlapping headers.",
                 kind_count[KIND_STATS]);
        if (errors == 0)
            $display("eth_ipv4_l4_header_parser test passed");
        else
            $display("eth_ipv4_l4_header_parser test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("eth_ipv4_l4_header_parser test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ehp_pkg.sv
hdl/ehp_front.sv
hdl/ehp_queue.sv
hdl/ehp_back.sv
hdl/eth_ipv4_l4_header_parser.sv
tb/testbench.sv
